>>> rtl/lsrc_pkg.sv
// shared constants and types of the line segment rectangle clipper
`default_nettype none

package lsrc_pkg;

   // default coordinate width
   localparam int COORD_BITS_DEF = 16;

   // interpolation quotient is capped at 2**QCAP_LOG2
   localparam int QCAP_LOG2 = 40;
   // signed interpolation offset, wide enough for the capped quotient
   localparam int DELTA_W = QCAP_LOG2 + 2;
   // base plus offset before saturation
   localparam int SUM_W = DELTA_W + 1;

   // window reset values
   localparam int WIN_LEFT_RST   = 0;
   localparam int WIN_TOP_RST    = 0;
   localparam int WIN_RIGHT_RST  = 1023;
   localparam int WIN_BOTTOM_RST = 767;

   typedef enum logic [1:0] {
      CSR_WIN_LEFT   = 2'd0,
      CSR_WIN_TOP    = 2'd1,
      CSR_WIN_RIGHT  = 2'd2,
      CSR_WIN_BOTTOM = 2'd3
   } csr_index_type;

   // pipeline stages of one interpolation unit: magnitudes, product, one stage
   // per quotient bit, signed offset
   function automatic int interp_latency(int cb);
      return 2 * cb + 3;
   endfunction

endpackage

`default_nettype wire

>>> rtl/lsrc_div.sv
// pipelined restoring divider, one quotient bit per stage
`default_nettype none

module lsrc_div #(
   parameter int N_W  = 2 * lsrc_pkg::COORD_BITS_DEF,
   parameter int D_W  = lsrc_pkg::COORD_BITS_DEF,
   parameter int SB_W = 1
) (
   input  logic            clock,
   input  logic            en,
   input  logic [N_W-1:0]  dividend,
   input  logic [D_W-1:0]  divisor,
   input  logic [SB_W-1:0] sb_in,
   output logic [N_W-1:0]  quotient,
   output logic [SB_W-1:0] sb_out
);
   import lsrc_pkg::*;

   // partial remainder, remaining dividend bits shifted up with quotient bits
   // filling in from the bottom
   logic [D_W-1:0]  rem_ff [N_W];
   logic [N_W-1:0]  nq_ff  [N_W];
   logic [D_W-1:0]  dvs_ff [N_W];
   logic [SB_W-1:0] sb_ff  [N_W];

   for (genvar i = 0; i < N_W; i++) begin : g_stage
      logic [D_W-1:0]  rem_prev;
      logic [N_W-1:0]  nq_prev;
      logic [D_W-1:0]  dvs_prev;
      logic [SB_W-1:0] sb_prev;
      logic [D_W:0]    part;
      logic [D_W:0]    trial;
      logic [D_W-1:0]  rem_in;
      logic [N_W-1:0]  nq_in;

      if (i == 0) begin : g_first
         assign rem_prev = '0;
         assign nq_prev  = dividend;
         assign dvs_prev = divisor;
         assign sb_prev  = sb_in;
      end else begin : g_next
         assign rem_prev = rem_ff[i-1];
         assign nq_prev  = nq_ff[i-1];
         assign dvs_prev = dvs_ff[i-1];
         assign sb_prev  = sb_ff[i-1];
      end

      always_comb begin
         part  = {rem_prev, nq_prev[N_W-1]};
         trial = part - {1'b0, dvs_prev};
         if (part >= {1'b0, dvs_prev}) begin
            rem_in = trial[D_W-1:0];
            nq_in  = {nq_prev[N_W-2:0], 1'b1};
         end else begin
            rem_in = part[D_W-1:0];
            nq_in  = {nq_prev[N_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= rem_in;
            nq_ff[i]  <= nq_in;
            dvs_ff[i] <= dvs_prev;
            sb_ff[i]  <= sb_prev;
         end
      end
   end

   assign quotient = nq_ff[N_W-1];
   assign sb_out   = sb_ff[N_W-1];

endmodule

`default_nettype wire

>>> rtl/lsrc_interp.sv
// interpolation offset d*num/den truncated toward zero, capped, pipelined
`default_nettype none

module lsrc_interp #(
   parameter int CB = lsrc_pkg::COORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                en,
   input  logic signed [CB:0]                  d,
   input  logic signed [CB:0]                  num,
   input  logic signed [CB:0]                  den,
   output logic signed [lsrc_pkg::DELTA_W-1:0] delta
);
   import lsrc_pkg::*;

   localparam int PW = 2 * CB;
   localparam int QW = (PW > QCAP_LOG2 + 1) ? PW : QCAP_LOG2 + 1;

   // differences of two coordinates stay within CB magnitude bits
   logic [CB-1:0] mag_d_ff, mag_n_ff, mag_den_ff;
   logic          neg_ff, zero_ff;

   logic [PW-1:0] prod_ff;
   logic [CB-1:0] den_b_ff;
   logic [1:0]    sb_b_ff;

   logic [PW-1:0] quot;
   logic [1:0]    sb_q;

   logic [QW-1:0]          q_ext, q_cap;
   logic [QCAP_LOG2:0]     q_mag;
   logic signed [DELTA_W-1:0] mag_s, delta_in, delta_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         mag_d_ff   <= d[CB]   ? CB'(-d)   : CB'(d);
         mag_n_ff   <= num[CB] ? CB'(-num) : CB'(num);
         mag_den_ff <= den[CB] ? CB'(-den) : CB'(den);
         neg_ff     <= d[CB] ^ num[CB] ^ den[CB];
         zero_ff    <= (den == '0);
         prod_ff    <= PW'(mag_d_ff) * PW'(mag_n_ff);
         den_b_ff   <= mag_den_ff;
         sb_b_ff    <= {neg_ff, zero_ff};
         delta_ff   <= delta_in;
      end
   end

   lsrc_div #(
      .N_W  (PW),
      .D_W  (CB),
      .SB_W (2)
   ) u_div (
      .clock    (clock),
      .en       (en),
      .dividend (prod_ff),
      .divisor  (den_b_ff),
      .sb_in    (sb_b_ff),
      .quotient (quot),
      .sb_out   (sb_q)
   );

   always_comb begin
      q_ext = QW'(quot);
      q_cap = (q_ext > (QW'(1) << QCAP_LOG2)) ? (QW'(1) << QCAP_LOG2) : q_ext;
      q_mag = q_cap[QCAP_LOG2:0];
      mag_s = DELTA_W'(q_mag);
      // zero divisor leaves the base untouched
      if (sb_q[0]) begin
         delta_in = '0;
      end else if (sb_q[1]) begin
         delta_in = -mag_s;
      end else begin
         delta_in = mag_s;
      end
   end

   assign delta = delta_ff;

endmodule

`default_nettype wire

>>> rtl/lsrc_delay.sv
// shift line carrying valid bits and item fields beside the dividers
`default_nettype none

module lsrc_delay #(
   parameter int W     = 1,
   parameter int DEPTH = 1
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         in_valid,
   input  logic [W-1:0] in_data,
   output logic         out_valid,
   output logic [W-1:0] out_data
);
   import lsrc_pkg::*;

   logic         valid_ff [DEPTH];
   logic [W-1:0] data_ff  [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_tap
      logic         valid_prev;
      logic [W-1:0] data_prev;

      if (i == 0) begin : g_first
         assign valid_prev = in_valid;
         assign data_prev  = in_data;
      end else begin : g_next
         assign valid_prev = valid_ff[i-1];
         assign data_prev  = data_ff[i-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            data_ff[i] <= data_prev;
         end
      end
   end

   assign out_valid = valid_ff[DEPTH-1];
   assign out_data  = data_ff[DEPTH-1];

endmodule

`default_nettype wire

>>> rtl/line_segment_rect_clipper.sv
// top level of the line segment rectangle clipper
//
// usage
//  - req_ channel: one segment per transfer, req_tdata holds ax, ay, bx, by
//    from the lowest bits up, each COORD_BITS wide, two's complement
//  - rsp_ channel: one result per segment, in order; rsp_tuser is visible,
//    rsp_tdata holds start_x, start_y, end_x, end_y from the lowest bits up
//  - csr_ port: write win_left, win_top, win_right, win_bottom by index while
//    no segment is in flight
//  - throughput one segment per cycle while req_tready is high; the path from a
//    request to its result runs through two interpolation passes of
//    2*COORD_BITS+3 stages each, mostly one stage per quotient bit of the
//    pipelined dividers
//  - reset clears all valid bits and loads the default window 0,0 .. 1023,767
//  - a stalled receiver first fills the output register, then a skid
//    register; only then does req_tready drop and the whole pipeline hold,
//    so nothing is lost or repeated; req_tready comes from a flop
`default_nettype none

module line_segment_rect_clipper #(
   parameter int COORD_BITS = lsrc_pkg::COORD_BITS_DEF,
   parameter int TDATA_W    = ((4 * COORD_BITS + 7) / 8) * 8
) (
   input  logic                    clock,
   input  logic                    reset,
   // request: ax, ay, bx, by
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [TDATA_W-1:0]      req_tdata,
   // result: start_x, start_y, end_x, end_y
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [TDATA_W-1:0]      rsp_tdata,
   // result: visible
   output logic                    rsp_tuser,
   // window registers
   input  logic                    csr_we,
   input  lsrc_pkg::csr_index_type csr_addr,
   input  logic [COORD_BITS-1:0]   csr_wdata
);
   import lsrc_pkg::*;

   localparam int CB  = COORD_BITS;
   localparam int LAT = interp_latency(COORD_BITS);
   localparam int PA_W = 3 + 4 * CB + 2 * (CB + 1);
   localparam int PB_W = 3 + 4 * CB;
   localparam int RES_W = 4 * CB;

   localparam logic signed [SUM_W-1:0] S_MAX = (SUM_W'(1) << (CB - 1)) - SUM_W'(1);
   localparam logic signed [SUM_W-1:0] S_MIN = -S_MAX - SUM_W'(1);

   typedef logic signed [CB-1:0]      coord_type;
   typedef logic signed [CB:0]        diff_type;
   typedef logic signed [DELTA_W-1:0] delta_type;

   // base plus offset, saturated to the coordinate range
   function automatic coord_type sat_add(coord_type base, delta_type delta);
      logic signed [SUM_W-1:0] s;
      s = SUM_W'(base) + SUM_W'(delta);
      if (s > S_MAX) begin
         return S_MAX[CB-1:0];
      end else if (s < S_MIN) begin
         return S_MIN[CB-1:0];
      end
      return s[CB-1:0];
   endfunction

   function automatic coord_type clamp_x(coord_type x, coord_type lo, coord_type hi);
      coord_type r;
      r = x;
      if (r < lo) begin
         r = lo;
      end
      if (r > hi) begin
         r = hi;
      end
      return r;
   endfunction

   // window registers
   coord_type win_left_ff, win_top_ff, win_right_ff, win_bottom_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_left_ff   <= CB'(WIN_LEFT_RST);
         win_top_ff    <= CB'(WIN_TOP_RST);
         win_right_ff  <= CB'(WIN_RIGHT_RST);
         win_bottom_ff <= CB'(WIN_BOTTOM_RST);
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_WIN_LEFT:   win_left_ff   <= csr_wdata;
            CSR_WIN_TOP:    win_top_ff    <= csr_wdata;
            CSR_WIN_RIGHT:  win_right_ff  <= csr_wdata;
            CSR_WIN_BOTTOM: win_bottom_ff <= csr_wdata;
         endcase
      end
   end

   // whole pipeline moves while the skid register is empty
   logic adv;
   logic skid_v_ff;
   assign adv        = !skid_v_ff;
   assign req_tready = adv;

   // stage 0: request capture
   logic      s0_v_ff;
   coord_type s0_ax_ff, s0_ay_ff, s0_bx_ff, s0_by_ff;

   // stage 1: trivial reject, order by x, dx and dy
   logic      s1_v_ff, s1_rej_ff, s1_rej_in;
   coord_type s1_x1_ff, s1_y1_ff, s1_x2_ff, s1_y2_ff;
   coord_type s1_x1_in, s1_y1_in, s1_x2_in, s1_y2_in;
   diff_type  s1_dx_ff, s1_dy_ff, s1_dx_in, s1_dy_in;

   always_comb begin
      s1_rej_in = (s0_ax_ff < win_left_ff   && s0_bx_ff < win_left_ff)  ||
                  (s0_ax_ff > win_right_ff  && s0_bx_ff > win_right_ff) ||
                  (s0_ay_ff < win_top_ff    && s0_by_ff < win_top_ff)   ||
                  (s0_ay_ff > win_bottom_ff && s0_by_ff > win_bottom_ff);
      if (s0_ax_ff > s0_bx_ff) begin
         s1_x1_in = s0_bx_ff;
         s1_y1_in = s0_by_ff;
         s1_x2_in = s0_ax_ff;
         s1_y2_in = s0_ay_ff;
      end else begin
         s1_x1_in = s0_ax_ff;
         s1_y1_in = s0_ay_ff;
         s1_x2_in = s0_bx_ff;
         s1_y2_in = s0_by_ff;
      end
      s1_dx_in = diff_type'(s1_x2_in) - diff_type'(s1_x1_in);
      s1_dy_in = diff_type'(s1_y2_in) - diff_type'(s1_y1_in);
   end

   // stage 2: x clip decisions and interpolation numerators
   logic      s2_v_ff, s2_rej_ff, s2_cl_ff, s2_cr_ff, s2_cl_in, s2_cr_in;
   coord_type s2_x1_ff, s2_y1_ff, s2_x2_ff, s2_y2_ff, s2_x1_in, s2_x2_in;
   diff_type  s2_dx_ff, s2_dy_ff, s2_num1_ff, s2_num2_ff;

   always_comb begin
      s2_cl_in = (s1_x1_ff < win_left_ff);
      s2_cr_in = (s1_x2_ff > win_right_ff);
      s2_x1_in = s2_cl_in ? win_left_ff  : s1_x1_ff;
      s2_x2_in = s2_cr_in ? win_right_ff : s1_x2_ff;
   end

   // x clip: both offsets run side by side, the right one is added to the
   // already clipped y1 afterwards
   delta_type da1, da2;

   lsrc_interp #(.CB(CB)) u_interp_left (
      .clock (clock),
      .en    (adv),
      .d     (s2_dy_ff),
      .num   (s2_num1_ff),
      .den   (s2_dx_ff),
      .delta (da1)
   );

   lsrc_interp #(.CB(CB)) u_interp_right (
      .clock (clock),
      .en    (adv),
      .d     (s2_dy_ff),
      .num   (s2_num2_ff),
      .den   (s2_dx_ff),
      .delta (da2)
   );

   logic            pa_v;
   logic [PA_W-1:0] pa_data;
   logic            pa_rej, pa_cl, pa_cr;
   coord_type       pa_x1, pa_y1, pa_x2, pa_y2;
   diff_type        pa_dx, pa_dy;

   lsrc_delay #(.W(PA_W), .DEPTH(LAT)) u_delay_x (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s2_v_ff),
      .in_data   ({s2_rej_ff, s2_cl_ff, s2_cr_ff, s2_x1_ff, s2_y1_ff, s2_x2_ff,
                   s2_y2_ff, s2_dx_ff, s2_dy_ff}),
      .out_valid (pa_v),
      .out_data  (pa_data)
   );

   assign {pa_rej, pa_cl, pa_cr, pa_x1, pa_y1, pa_x2, pa_y2, pa_dx, pa_dy} = pa_data;

   // stage 3: clipped y1
   logic      s3_v_ff, s3_rej_ff, s3_cr_ff;
   coord_type s3_x1_ff, s3_y1_ff, s3_x2_ff, s3_y2_ff, s3_y1_in;
   diff_type  s3_dx_ff, s3_dy_ff;
   delta_type s3_d2_ff;

   assign s3_y1_in = pa_cl ? sat_add(pa_y1, da1) : pa_y1;

   // stage 4: clipped y2
   logic      s4_v_ff, s4_rej_ff;
   coord_type s4_x1_ff, s4_y1_ff, s4_x2_ff, s4_y2_ff, s4_y2_in;
   diff_type  s4_dx_ff, s4_dy_ff;

   assign s4_y2_in = s3_cr_ff ? sat_add(s3_y1_ff, s3_d2_ff) : s3_y2_ff;

   // stage 5: order by y
   logic      s5_v_ff, s5_rej_ff, s5_swap;
   coord_type s5_x1_ff, s5_y1_ff, s5_x2_ff, s5_y2_ff;
   diff_type  s5_dx_ff, s5_dy_ff;

   assign s5_swap = (s4_y1_ff > s4_y2_ff);

   // stage 6: y clip decisions and numerators, original dx and dy kept
   logic      s6_v_ff, s6_rej_ff, s6_ct_ff, s6_cb_ff, s6_ct_in, s6_cb_in;
   coord_type s6_x1_ff, s6_y1_ff, s6_x2_ff, s6_y2_ff, s6_y1_in, s6_y2_in;
   diff_type  s6_dx_ff, s6_dy_ff, s6_num3_ff, s6_num4_ff;

   always_comb begin
      s6_ct_in = (s5_y1_ff < win_top_ff);
      s6_cb_in = (s5_y2_ff > win_bottom_ff);
      s6_y1_in = s6_ct_in ? win_top_ff    : s5_y1_ff;
      s6_y2_in = s6_cb_in ? win_bottom_ff : s5_y2_ff;
   end

   delta_type db1, db2;

   lsrc_interp #(.CB(CB)) u_interp_top (
      .clock (clock),
      .en    (adv),
      .d     (s6_dx_ff),
      .num   (s6_num3_ff),
      .den   (s6_dy_ff),
      .delta (db1)
   );

   lsrc_interp #(.CB(CB)) u_interp_bottom (
      .clock (clock),
      .en    (adv),
      .d     (s6_dx_ff),
      .num   (s6_num4_ff),
      .den   (s6_dy_ff),
      .delta (db2)
   );

   logic            pb_v;
   logic [PB_W-1:0] pb_data;
   logic            pb_rej, pb_ct, pb_cb;
   coord_type       pb_x1, pb_y1, pb_x2, pb_y2;

   lsrc_delay #(.W(PB_W), .DEPTH(LAT)) u_delay_y (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s6_v_ff),
      .in_data   ({s6_rej_ff, s6_ct_ff, s6_cb_ff, s6_x1_ff, s6_y1_ff, s6_x2_ff,
                   s6_y2_ff}),
      .out_valid (pb_v),
      .out_data  (pb_data)
   );

   assign {pb_rej, pb_ct, pb_cb, pb_x1, pb_y1, pb_x2, pb_y2} = pb_data;

   // stage 7: clipped and clamped x1
   logic      s7_v_ff, s7_rej_ff, s7_cb_ff;
   coord_type s7_x1_ff, s7_y1_ff, s7_x2_ff, s7_y2_ff, s7_x1_in;
   delta_type s7_d4_ff;

   assign s7_x1_in = pb_ct ? clamp_x(sat_add(pb_x1, db1), win_left_ff, win_right_ff)
                           : pb_x1;

   // stage 8: clipped and clamped x2, rejected segments read as zero
   logic             s8_v_ff, s8_vis_ff;
   logic [RES_W-1:0] s8_data_ff, s8_data_in;
   coord_type        s8_x2;

   always_comb begin
      s8_x2 = s7_cb_ff ? clamp_x(sat_add(s7_x1_ff, s7_d4_ff), win_left_ff, win_right_ff)
                       : s7_x2_ff;
      s8_data_in = s7_rej_ff ? '0 : {s7_y2_ff, s8_x2, s7_y1_ff, s7_x1_ff};
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
         s6_v_ff <= 1'b0;
         s7_v_ff <= 1'b0;
         s8_v_ff <= 1'b0;
      end else if (adv) begin
         s0_v_ff <= req_tvalid;
         s1_v_ff <= s0_v_ff;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= pa_v;
         s4_v_ff <= s3_v_ff;
         s5_v_ff <= s4_v_ff;
         s6_v_ff <= s5_v_ff;
         s7_v_ff <= pb_v;
         s8_v_ff <= s7_v_ff;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (adv) begin
         s0_ax_ff <= req_tdata[CB-1:0];
         s0_ay_ff <= req_tdata[2*CB-1:CB];
         s0_bx_ff <= req_tdata[3*CB-1:2*CB];
         s0_by_ff <= req_tdata[4*CB-1:3*CB];

         s1_rej_ff <= s1_rej_in;
         s1_x1_ff  <= s1_x1_in;
         s1_y1_ff  <= s1_y1_in;
         s1_x2_ff  <= s1_x2_in;
         s1_y2_ff  <= s1_y2_in;
         s1_dx_ff  <= s1_dx_in;
         s1_dy_ff  <= s1_dy_in;

         s2_rej_ff  <= s1_rej_ff;
         s2_cl_ff   <= s2_cl_in;
         s2_cr_ff   <= s2_cr_in;
         s2_x1_ff   <= s2_x1_in;
         s2_y1_ff   <= s1_y1_ff;
         s2_x2_ff   <= s2_x2_in;
         s2_y2_ff   <= s1_y2_ff;
         s2_dx_ff   <= s1_dx_ff;
         s2_dy_ff   <= s1_dy_ff;
         s2_num1_ff <= diff_type'(win_left_ff)  - diff_type'(s1_x1_ff);
         s2_num2_ff <= diff_type'(win_right_ff) - diff_type'(s2_x1_in);

         s3_rej_ff <= pa_rej;
         s3_cr_ff  <= pa_cr;
         s3_x1_ff  <= pa_x1;
         s3_y1_ff  <= s3_y1_in;
         s3_x2_ff  <= pa_x2;
         s3_y2_ff  <= pa_y2;
         s3_dx_ff  <= pa_dx;
         s3_dy_ff  <= pa_dy;
         s3_d2_ff  <= da2;

         s4_rej_ff <= s3_rej_ff;
         s4_x1_ff  <= s3_x1_ff;
         s4_y1_ff  <= s3_y1_ff;
         s4_x2_ff  <= s3_x2_ff;
         s4_y2_ff  <= s4_y2_in;
         s4_dx_ff  <= s3_dx_ff;
         s4_dy_ff  <= s3_dy_ff;

         s5_rej_ff <= s4_rej_ff;
         s5_x1_ff  <= s5_swap ? s4_x2_ff : s4_x1_ff;
         s5_y1_ff  <= s5_swap ? s4_y2_ff : s4_y1_ff;
         s5_x2_ff  <= s5_swap ? s4_x1_ff : s4_x2_ff;
         s5_y2_ff  <= s5_swap ? s4_y1_ff : s4_y2_ff;
         s5_dx_ff  <= s4_dx_ff;
         s5_dy_ff  <= s4_dy_ff;

         s6_rej_ff  <= s5_rej_ff;
         s6_ct_ff   <= s6_ct_in;
         s6_cb_ff   <= s6_cb_in;
         s6_x1_ff   <= s5_x1_ff;
         s6_y1_ff   <= s6_y1_in;
         s6_x2_ff   <= s5_x2_ff;
         s6_y2_ff   <= s6_y2_in;
         s6_dx_ff   <= s5_dx_ff;
         s6_dy_ff   <= s5_dy_ff;
         s6_num3_ff <= diff_type'(win_top_ff)    - diff_type'(s5_y1_ff);
         s6_num4_ff <= diff_type'(win_bottom_ff) - diff_type'(s6_y1_in);

         s7_rej_ff <= pb_rej;
         s7_cb_ff  <= pb_cb;
         s7_x1_ff  <= s7_x1_in;
         s7_y1_ff  <= pb_y1;
         s7_x2_ff  <= pb_x2;
         s7_y2_ff  <= pb_y2;
         s7_d4_ff  <= db2;

         s8_vis_ff  <= !s7_rej_ff;
         s8_data_ff <= s8_data_in;
      end
   end

   // output register and skid register
   logic             out_v_ff, out_vis_ff, skid_vis_ff;
   logic [RES_W-1:0] out_data_ff, skid_data_ff;
   logic             out_stuck;

   assign out_stuck = out_v_ff && !rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (adv) begin
         if (out_stuck) begin
            skid_v_ff <= s8_v_ff;
         end else begin
            out_v_ff <= s8_v_ff;
         end
      end else if (rsp_tready) begin
         // skid drains into the output register
         out_v_ff  <= 1'b1;
         skid_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (out_stuck) begin
            skid_vis_ff  <= s8_vis_ff;
            skid_data_ff <= s8_data_ff;
         end else begin
            out_vis_ff  <= s8_vis_ff;
            out_data_ff <= s8_data_ff;
         end
      end else if (rsp_tready) begin
         out_vis_ff  <= skid_vis_ff;
         out_data_ff <= skid_data_ff;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tuser  = out_vis_ff;
   assign rsp_tdata  = TDATA_W'(out_data_ff);

endmodule

`default_nettype wire
